// ===== design/bca_pkg.sv =====
// Shared constants for the bitmap cluster allocator: field widths, operation
// and status codes, register reset value and default sizing.
// No dependencies.
package bca_pkg;

	localparam int OPCODE_W  = 2;
	localparam int CLUSTER_W = 12;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 13;

	localparam int MAX_CLUSTERS_DEF = 4096;
	localparam int WORD_BITS_DEF    = 32;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

	localparam logic [OPCODE_W-1:0] OP_ALLOC  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FREE   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_FORMAT = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

endpackage

// ===== design/bca_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
module bca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/bca_locate.sv =====
// Two-stage split of a cluster number into bitmap word, word base cluster
// and bit position (MSB-first). Uses bca_pkg.
module bca_locate
	import bca_pkg::*;
#(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
	parameter int WORD_BITS    = WORD_BITS_DEF,
	localparam int NUM_WORDS = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS,
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
	localparam int BW        = $clog2(WORD_BITS),
	localparam int CNTW      = $clog2(MAX_CLUSTERS + 1),
	localparam int CW        = (CNTW > COUNT_W) ? CNTW : COUNT_W
) (
	input  logic                 clk,
	input  logic [CLUSTER_W-1:0] cluster,
	output logic [AW-1:0]        word_s2,
	output logic [CW-1:0]        base_s2,
	output logic [BW-1:0]        bit_s2
);

	// quotient by reciprocal multiply, exact for every CLUSTER_W-bit numerator
	localparam int SH  = CLUSTER_W + BW;
	localparam int MW  = SH + 1;
	localparam int PW  = CLUSTER_W + MW;
	localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + WORD_BITS - 1) / WORD_BITS);

	logic [PW-1:0]        prod;
	logic [CLUSTER_W-1:0] q_s1;
	logic [CLUSTER_W-1:0] cluster_s1;
	logic [CW-1:0]        base_full;
	logic [CW-1:0]        rem_full;

	assign prod = PW'(cluster) * PW'(RECIP);

	always_ff @(posedge clk) begin
		q_s1       <= CLUSTER_W'(prod >> SH);
		cluster_s1 <= cluster;
	end

	assign base_full = CW'(q_s1) * CW'(WORD_BITS);
	assign rem_full  = CW'(cluster_s1) - base_full;

	always_ff @(posedge clk) begin
		word_s2 <= q_s1[AW-1:0];
		base_s2 <= base_full;
		bit_s2  <= BW'(WORD_BITS - 1) - rem_full[BW-1:0];
	end

endmodule

// ===== design/bca_find.sv =====
// First-free finder over one bitmap word: lowest cluster (highest bit) that
// is set and still below the count limit. Uses bca_pkg.
module bca_find
	import bca_pkg::*;
#(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
	parameter int WORD_BITS    = WORD_BITS_DEF,
	localparam int BW   = $clog2(WORD_BITS),
	localparam int CNTW = $clog2(MAX_CLUSTERS + 1),
	localparam int CW   = (CNTW > COUNT_W) ? CNTW : COUNT_W
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic [CW-1:0]        remain,
	output logic                 hit,
	output logic [BW-1:0]        idx
);

	// later (higher) bits override: bit WORD_BITS-1 is the lowest cluster
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int p = 0; p < WORD_BITS; p++) begin
			if (word[p] && (CW'(WORD_BITS - 1 - p) < remain)) begin
				hit = 1'b1;
				idx = BW'(p);
			end
		end
	end

endmodule

// ===== design/bitmap_cluster_allocator.sv =====
// Bitmap cluster allocator: keeps one free bit per cluster (set = free,
// MSB-first inside each word) in a synchronous RAM of NUM_WORDS words and
// serves one transaction at a time; the input stalls from acceptance until
// the result is loaded into the output register. Allocate scans the words
// from word 0, one word per cycle through the RAM read port, and takes the
// lowest free cluster below min(cluster_count, MAX_CLUSTERS). An allocate
// that finds nothing free ends once the last word read below the count is
// checked. Free passes through the cluster-to-word split (S_LOC0, S_LOC1),
// a RAM read (S_FREE_RD) and the write back (S_FREE_WR), then loads the
// result in S_DONE and returns to idle. Format, an out-of-range free, an
// allocate with a zero count and the unused opcode go straight to S_DONE.
// Format only drops the per-word written flags, and a word whose flag is
// clear reads as the formatted pattern (clusters 0 and 1 used), so reset
// needs no clearing pass either. A full, stalled output register holds the
// finished result back in S_DONE for as long as it stays full. cluster_count
// may be written only while no transaction is in progress. A finished
// result sits in the output register and the next input transaction is
// taken while it waits.
module bitmap_cluster_allocator
	import bca_pkg::*;
#(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
	parameter int WORD_BITS    = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [COUNT_W-1:0]   cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OPCODE_W-1:0]  opcode,
	input  logic [CLUSTER_W-1:0] cluster,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CLUSTER_W-1:0] cluster_number,
	output logic [STATUS_W-1:0]  status
);

	localparam int NUM_WORDS = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int CNTW      = $clog2(MAX_CLUSTERS + 1);
	localparam int CW        = (CNTW > COUNT_W) ? CNTW : COUNT_W;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_LOC0    = 3'd1;
	localparam logic [2:0] S_LOC1    = 3'd2;
	localparam logic [2:0] S_FREE_RD = 3'd3;
	localparam logic [2:0] S_FREE_WR = 3'd4;
	localparam logic [2:0] S_SCAN    = 3'd5;
	localparam logic [2:0] S_DONE    = 3'd6;

	// Formatted contents of the word whose first cluster is base.
	function automatic logic [WORD_BITS-1:0] fmt_word(input logic [CW-1:0] base);
		logic [WORD_BITS-1:0] w;
		logic [CW-1:0]        c;
		w = '0;
		for (int p = 0; p < WORD_BITS; p++) begin
			c    = base + CW'(WORD_BITS - 1 - p);
			w[p] = (c >= CW'(2)) && (c < CW'(MAX_CLUSTERS));
		end
		return w;
	endfunction

	logic [2:0]           state_q;
	logic [COUNT_W-1:0]   count_q;
	logic [NUM_WORDS-1:0] written_q;
	logic [CLUSTER_W-1:0] cluster_q;

	logic [CLUSTER_W-1:0] res_num_q;
	logic [STATUS_W-1:0]  res_st_q;
	logic                 out_valid_q;
	logic [CLUSTER_W-1:0] out_num_q;
	logic [STATUS_W-1:0]  out_st_q;

	// scan issue side
	logic [AW-1:0]        scan_addr_q;
	logic [CW-1:0]        scan_base_q;
	logic                 scan_more_q;
	logic [CW-1:0]        scan_base_nxt;

	// read pipeline: registered alongside the RAM read, so it lines up with rd_data
	logic                 pend_s1;
	logic [AW-1:0]        addr_s1;
	logic [CW-1:0]        base_s1;
	logic                 wrt_s1;
	logic [BW-1:0]        bit_s1;

	logic [CW-1:0]        count_ext;
	logic [CW-1:0]        limit;
	logic                 accept;

	logic [AW-1:0]        loc_word;
	logic [CW-1:0]        loc_base;
	logic [BW-1:0]        loc_bit;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [WORD_BITS-1:0] rd_data;
	logic [WORD_BITS-1:0] word_cur;
	logic                 hit;
	logic [BW-1:0]        hit_idx;
	logic                 scan_hit;
	logic [CW-1:0]        found;
	logic                 wr_en;
	logic [WORD_BITS-1:0] wr_data;

	// count above capacity acts as capacity
	assign count_ext = CW'(count_q);
	assign limit     = (count_ext > CW'(MAX_CLUSTERS)) ? CW'(MAX_CLUSTERS) : count_ext;

	// one transaction in flight: the write back always lands before the next read
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	assign out_valid      = out_valid_q;
	assign cluster_number = out_num_q;
	assign status         = out_st_q;

	bca_locate #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.WORD_BITS   (WORD_BITS)
	) u_locate (
		.clk    (clk),
		.cluster(cluster_q),
		.word_s2(loc_word),
		.base_s2(loc_base),
		.bit_s2 (loc_bit)
	);

	assign rd_en   = ((state_q == S_SCAN) && scan_more_q) || (state_q == S_FREE_RD);
	assign rd_addr = (state_q == S_FREE_RD) ? loc_word : scan_addr_q;

	bca_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NUM_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// a word never written since reset or format reads as formatted
	assign word_cur = wrt_s1 ? rd_data : fmt_word(base_s1);

	bca_find #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.WORD_BITS   (WORD_BITS)
	) u_find (
		.word  (word_cur),
		.remain(limit - base_s1),
		.hit   (hit),
		.idx   (hit_idx)
	);

	assign scan_hit      = (state_q == S_SCAN) && pend_s1 && hit;
	assign found         = base_s1 + CW'(WORD_BITS - 1) - CW'(hit_idx);
	assign scan_base_nxt = scan_base_q + CW'(WORD_BITS);

	// write back: set the bit on free, clear the found bit on allocate
	assign wr_en   = scan_hit || (state_q == S_FREE_WR);
	assign wr_data = (state_q == S_FREE_WR) ?
		(word_cur | (WORD_BITS'(1) << bit_s1)) :
		(word_cur & ~(WORD_BITS'(1) << hit_idx));

	// read pipeline payload follows the address every cycle
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		base_s1 <= (state_q == S_FREE_RD) ? loc_base : scan_base_q;
		wrt_s1  <= written_q[rd_addr];
		bit_s1  <= loc_bit;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cluster_q <= cluster;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			written_q   <= '0;
			pend_s1     <= 1'b0;
			scan_more_q <= 1'b0;
			scan_addr_q <= '0;
			scan_base_q <= '0;
			res_num_q   <= '0;
			res_st_q    <= ST_OK;
		end else begin
			pend_s1 <= rd_en;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_num_q <= '0;
						case (opcode)
							OP_ALLOC: begin
								if (limit == '0) begin
									res_st_q <= ST_NONE_FREE;
									state_q  <= S_DONE;
								end else begin
									res_st_q    <= ST_OK;
									scan_addr_q <= '0;
									scan_base_q <= '0;
									scan_more_q <= 1'b1;
									state_q     <= S_SCAN;
								end
							end
							OP_FREE: begin
								if (CW'(cluster) >= limit) begin
									res_st_q <= ST_RANGE;
									state_q  <= S_DONE;
								end else begin
									res_st_q <= ST_OK;
									state_q  <= S_LOC0;
								end
							end
							OP_FORMAT: begin
								res_st_q  <= ST_OK;
								written_q <= '0;
								state_q   <= S_DONE;
							end
							default: begin
								res_st_q <= ST_OK;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_LOC0: begin
					state_q <= S_LOC1;
				end
				S_LOC1: begin
					state_q <= S_FREE_RD;
				end
				S_FREE_RD: begin
					state_q <= S_FREE_WR;
				end
				S_FREE_WR: begin
					written_q[addr_s1] <= 1'b1;
					state_q            <= S_DONE;
				end
				S_SCAN: begin
					if (scan_hit) begin
						written_q[addr_s1] <= 1'b1;
						res_num_q          <= found[CLUSTER_W-1:0];
						scan_more_q        <= 1'b0;
						state_q            <= S_DONE;
					end else begin
						// advance the read address while words remain below the limit
						if (scan_more_q) begin
							scan_addr_q <= scan_addr_q + AW'(1);
							scan_base_q <= scan_base_nxt;
							scan_more_q <= (scan_base_nxt < limit);
						end
						if (!pend_s1 && !scan_more_q) begin
							res_st_q <= ST_NONE_FREE;
							state_q  <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register: load when empty or being taken, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && (!out_valid_q || !out_stall)) begin
			out_num_q <= res_num_q;
			out_st_q  <= res_st_q;
		end
	end

endmodule
